// ----- sv/exptok_pkg.sv -----
package exptok_pkg;

    localparam int MAX_TEXT_BYTES = 65536;
    localparam int POS_W = $clog2(MAX_TEXT_BYTES);
    localparam int LEN_W = POS_W + 1;
    localparam int CHAR_W = 8;
    localparam int VALUE_W = 32;
    localparam int FIELD_W = 16;
    localparam int KW_LEN = 6;
    localparam int KW_W = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LC_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UC_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;

    typedef enum logic [3:0] {
        KIND_NONE   = 4'd0,
        KIND_INT    = 4'd1,
        KIND_IDENT  = 4'd2,
        KIND_RETURN = 4'd3,
        KIND_PLUS   = 4'd4,
        KIND_MINUS  = 4'd5,
        KIND_STAR   = 4'd6,
        KIND_SLASH  = 4'd7,
        KIND_LPAREN = 4'd8,
        KIND_RPAREN = 4'd9,
        KIND_EQ     = 4'd10,
        KIND_SEMI   = 4'd11,
        KIND_EOF    = 4'd12
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_IDENT  = 3'b010,
        MODE_NUMBER = 3'b100
    } mode_t;

    typedef struct packed {
        kind_t                kind;
        logic [VALUE_W-1:0]   value;
        logic [FIELD_W-1:0]   start;
        logic [FIELD_W-1:0]   length;
        logic                 last;
    } token_t;

    typedef struct packed {
        logic   first_valid;
        logic   second_valid;
        token_t first;
        token_t second;
    } token_pair_t;

    function automatic logic [CHAR_W-1:0] kw_char(input logic [KW_W-1:0] idx);
        logic [CHAR_W-1:0] ch;
        case (idx)
            3'd0:    ch = 8'h72;
            3'd1:    ch = 8'h65;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h75;
            3'd4:    ch = 8'h72;
            3'd5:    ch = 8'h6E;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
        return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z)
            || c == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic kind_t punct_kind(input logic [CHAR_W-1:0] c);
        kind_t k;
        case (c)
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_STAR:   k = KIND_STAR;
            CH_SLASH:  k = KIND_SLASH;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_EQ:     k = KIND_EQ;
            CH_SEMI:   k = KIND_SEMI;
            CH_NUL:    k = KIND_EOF;
            default:   k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

// ----- sv/exptok_scan.sv -----
module exptok_scan
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  logic [exptok_pkg::CHAR_W-1:0]         char_code,
    output exptok_pkg::token_pair_t               pair
);

    exptok_pkg::mode_t                 mode_reg, mode_next;
    logic [exptok_pkg::VALUE_W-1:0]    acc_reg, acc_next;
    logic [exptok_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [exptok_pkg::POS_W-1:0]      wstart_reg, wstart_next;
    logic [exptok_pkg::KW_W-1:0]       kprog_reg, kprog_next;
    logic                              kalive_reg, kalive_next;

    logic                              alpha;
    logic                              digit;
    logic                              space;
    logic [exptok_pkg::POS_W-1:0]      pos_inc;
    logic [exptok_pkg::LEN_W-1:0]      len_raw;
    logic [exptok_pkg::LEN_W-1:0]      word_len;
    logic [exptok_pkg::VALUE_W-1:0]    digit_val;
    logic                              kw_hit;
    logic                              pend_valid;
    exptok_pkg::token_t                pend_tok;
    logic                              own_valid;
    exptok_pkg::token_t                own_tok;
    exptok_pkg::kind_t                 own_kind;

    always_comb
    begin
        alpha     = exptok_pkg::is_alpha(char_code);
        digit     = exptok_pkg::is_digit(char_code);
        space     = char_code == exptok_pkg::CH_SPACE || char_code == exptok_pkg::CH_TAB
                 || char_code == exptok_pkg::CH_LF;
        pos_inc   = (pos_reg == exptok_pkg::POS_W'(exptok_pkg::MAX_TEXT_BYTES - 1))
                  ? '0 : pos_reg + 1'b1;
        len_raw   = {1'b0, pos_reg} - {1'b0, wstart_reg};
        word_len  = (pos_reg >= wstart_reg) ? len_raw
                  : len_raw + exptok_pkg::LEN_W'(exptok_pkg::MAX_TEXT_BYTES);
        digit_val = exptok_pkg::VALUE_W'(char_code - exptok_pkg::CH_ZERO);
        kw_hit    = kalive_reg && kprog_reg < exptok_pkg::KW_W'(exptok_pkg::KW_LEN)
                 && char_code == exptok_pkg::kw_char(kprog_reg);
        own_kind  = exptok_pkg::punct_kind(char_code);

        mode_next   = mode_reg;
        acc_next    = acc_reg;
        pos_next    = pos_reg;
        wstart_next = wstart_reg;
        kprog_next  = kprog_reg;
        kalive_next = kalive_reg;
        pend_valid  = 1'b0;
        pend_tok    = '0;
        own_valid   = 1'b0;
        own_tok     = '0;

        if (mode_reg == exptok_pkg::MODE_IDENT && (alpha || digit))
        begin
            kprog_next  = kw_hit ? kprog_reg + 1'b1 : kprog_reg;
            kalive_next = kw_hit;
            pos_next    = pos_inc;
        end
        else if (mode_reg == exptok_pkg::MODE_NUMBER && digit)
        begin
            acc_next = (acc_reg << 3) + (acc_reg << 1) + digit_val;
            pos_next = pos_inc;
        end
        else
        begin
            if (mode_reg == exptok_pkg::MODE_IDENT)
            begin
                pend_valid = 1'b1;
                if (kalive_reg && kprog_reg == exptok_pkg::KW_W'(exptok_pkg::KW_LEN))
                begin
                    pend_tok.kind = exptok_pkg::KIND_RETURN;
                end
                else
                begin
                    pend_tok.kind   = exptok_pkg::KIND_IDENT;
                    pend_tok.start  = exptok_pkg::FIELD_W'(wstart_reg);
                    pend_tok.length = exptok_pkg::FIELD_W'(word_len);
                end
            end
            else if (mode_reg == exptok_pkg::MODE_NUMBER)
            begin
                pend_valid     = 1'b1;
                pend_tok.kind  = exptok_pkg::KIND_INT;
                pend_tok.value = acc_reg;
                acc_next       = '0;
            end
            mode_next = exptok_pkg::MODE_IDLE;

            if (space)
            begin
                pos_next = pos_inc;
            end
            else if (alpha)
            begin
                wstart_next = pos_reg;
                kalive_next = char_code == exptok_pkg::kw_char('0);
                kprog_next  = (char_code == exptok_pkg::kw_char('0)) ? 3'd1 : 3'd0;
                mode_next   = exptok_pkg::MODE_IDENT;
                pos_next    = pos_inc;
            end
            else if (digit)
            begin
                acc_next  = digit_val;
                mode_next = exptok_pkg::MODE_NUMBER;
                pos_next  = pos_inc;
            end
            else
            begin
                own_valid    = 1'b1;
                own_tok.kind = own_kind;
                own_tok.last = 1'b1;
                if (own_kind == exptok_pkg::KIND_EOF)
                begin
                    mode_next   = exptok_pkg::MODE_IDLE;
                    acc_next    = '0;
                    pos_next    = '0;
                    wstart_next = '0;
                    kprog_next  = '0;
                    kalive_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end
        end

        pend_tok.last = !own_valid;

        pair.first_valid  = pend_valid || own_valid;
        pair.second_valid = pend_valid && own_valid;
        pair.first        = pend_valid ? pend_tok : own_tok;
        pair.second       = own_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= exptok_pkg::MODE_IDLE;
            acc_reg    <= '0;
            pos_reg    <= '0;
            wstart_reg <= '0;
            kprog_reg  <= '0;
            kalive_reg <= 1'b1;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            acc_reg    <= acc_next;
            pos_reg    <= pos_next;
            wstart_reg <= wstart_next;
            kprog_reg  <= kprog_next;
            kalive_reg <= kalive_next;
        end
    end

endmodule

// ----- sv/exptok_queue.sv -----
module exptok_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  exptok_pkg::token_pair_t pair,
    output logic                    full,
    output logic                    out_valid,
    input  logic                    out_stall,
    output exptok_pkg::token_t      out_tok
);

    exptok_pkg::token_t                 entry_reg [exptok_pkg::QUEUE_DEPTH];
    logic [exptok_pkg::QPTR_W-1:0]      wr_reg, wr_next;
    logic [exptok_pkg::QPTR_W-1:0]      rd_reg, rd_next;
    logic [exptok_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                               pop;
    logic                               wr0;
    logic                               wr1;
    logic [exptok_pkg::QPTR_W-1:0]      wr_plus1;

    always_comb
    begin
        out_valid  = count_reg != '0;
        out_tok    = entry_reg[rd_reg];
        full       = count_reg >= exptok_pkg::QCNT_W'(exptok_pkg::QUEUE_DEPTH - 1);
        pop        = out_valid && !out_stall;
        wr0        = push && pair.first_valid;
        wr1        = push && pair.second_valid;
        wr_plus1   = wr_reg + 1'b1;
        wr_next    = wr_reg + exptok_pkg::QPTR_W'(wr0) + exptok_pkg::QPTR_W'(wr1);
        rd_next    = rd_reg + exptok_pkg::QPTR_W'(pop);
        count_next = count_reg + exptok_pkg::QCNT_W'(wr0) + exptok_pkg::QCNT_W'(wr1)
                   - exptok_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (wr0)
        begin
            entry_reg[wr_reg] <= pair.first;
        end
        if (wr1)
        begin
            entry_reg[wr_plus1] <= pair.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- sv/expression_tokenizer.sv -----
// Streaming lexer that takes one source byte per request and returns the tokens it
// completes. A byte is taken in the same cycle it is offered while the four-entry
// result queue holds at most two tokens, so a steady text stream runs at one byte
// per cycle; results leave the queue one per cycle while out_stall is low, which sets
// the sustained rate when many bytes each give two tokens (a byte that ends a word
// or number and is itself a token). Identifiers are reported by start offset and
// length, the exact word "return" as its own token, and a zero byte gives end of
// text and restarts the position count.
module expression_tokenizer
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [exptok_pkg::CHAR_W-1:0]       char_code,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [3:0]                          token_kind,
    output logic [exptok_pkg::VALUE_W-1:0]      int_value,
    output logic [exptok_pkg::FIELD_W-1:0]      ident_start,
    output logic [exptok_pkg::FIELD_W-1:0]      ident_length,
    output logic                                last_of_item
);

    exptok_pkg::token_pair_t pair;
    exptok_pkg::token_t      out_tok;
    logic                    full;
    logic                    accept;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    exptok_scan u_scan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_code (char_code),
        .pair      (pair)
    );

    exptok_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .pair      (pair),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_tok   (out_tok)
    );

    assign token_kind   = out_tok.kind;
    assign int_value    = out_tok.value;
    assign ident_start  = out_tok.start;
    assign ident_length = out_tok.length;
    assign last_of_item = out_tok.last;

endmodule

// ----- bench/expression_tokenizer_checker.sv -----
`timescale 1ns / 1ps

module expression_tokenizer_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [exptok_pkg::CHAR_W-1:0]   char_code,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [3:0]                      token_kind,
    input  logic [exptok_pkg::VALUE_W-1:0]  int_value,
    input  logic [exptok_pkg::FIELD_W-1:0]  ident_start,
    input  logic [exptok_pkg::FIELD_W-1:0]  ident_length,
    input  logic                            last_of_item,
    output int                              failures,
    output int                              outstanding,
    output int                              tokens_checked
);

    localparam logic [exptok_pkg::CHAR_W-1:0] KEYWORD [exptok_pkg::KW_LEN] =
        '{"r", "e", "t", "u", "r", "n"};

    exptok_pkg::mode_t                  scan_state;
    logic [exptok_pkg::VALUE_W-1:0]     number_value;
    logic [exptok_pkg::POS_W-1:0]       position;
    logic [exptok_pkg::POS_W-1:0]       word_begin;
    logic [exptok_pkg::KW_W-1:0]        keyword_matched;
    logic                               keyword_possible;

    exptok_pkg::token_t                 expected_tokens [$];
    exptok_pkg::token_t                 oldest;
    int                                 error_count = 0;
    int                                 checked_count = 0;

    function automatic logic char_is_letter(input logic [exptok_pkg::CHAR_W-1:0] c);
        logic lower;
        logic upper;
        lower = (c >= exptok_pkg::CH_LC_A) && (c <= exptok_pkg::CH_LC_Z);
        upper = (c >= exptok_pkg::CH_UC_A) && (c <= exptok_pkg::CH_UC_Z);
        return lower || upper || (c == exptok_pkg::CH_UNDER);
    endfunction

    function automatic logic char_is_digit(input logic [exptok_pkg::CHAR_W-1:0] c);
        return (c >= exptok_pkg::CH_ZERO) && (c <= exptok_pkg::CH_NINE);
    endfunction

    function automatic exptok_pkg::kind_t single_char_kind(
        input logic [exptok_pkg::CHAR_W-1:0] c);
        exptok_pkg::kind_t k;
        k = exptok_pkg::KIND_NONE;
        if (c == exptok_pkg::CH_PLUS) k = exptok_pkg::KIND_PLUS;
        if (c == exptok_pkg::CH_MINUS) k = exptok_pkg::KIND_MINUS;
        if (c == exptok_pkg::CH_STAR) k = exptok_pkg::KIND_STAR;
        if (c == exptok_pkg::CH_SLASH) k = exptok_pkg::KIND_SLASH;
        if (c == exptok_pkg::CH_LPAREN) k = exptok_pkg::KIND_LPAREN;
        if (c == exptok_pkg::CH_RPAREN) k = exptok_pkg::KIND_RPAREN;
        if (c == exptok_pkg::CH_EQ) k = exptok_pkg::KIND_EQ;
        if (c == exptok_pkg::CH_SEMI) k = exptok_pkg::KIND_SEMI;
        if (c == exptok_pkg::CH_NUL) k = exptok_pkg::KIND_EOF;
        return k;
    endfunction

    function automatic exptok_pkg::token_t make_token(
        input exptok_pkg::kind_t k,
        input logic [exptok_pkg::VALUE_W-1:0] v,
        input logic [exptok_pkg::FIELD_W-1:0] s,
        input logic [exptok_pkg::FIELD_W-1:0] l);
        exptok_pkg::token_t t;
        t.kind = k;
        t.value = v;
        t.start = s;
        t.length = l;
        t.last = 1'b0;
        return t;
    endfunction

    task automatic restart_scanner();
        scan_state = exptok_pkg::MODE_IDLE;
        number_value = '0;
        position = '0;
        word_begin = '0;
        keyword_matched = '0;
        keyword_possible = 1'b1;
    endtask

    task automatic track_keyword(input logic [exptok_pkg::CHAR_W-1:0] c);
        if (keyword_possible
            && (keyword_matched < exptok_pkg::KW_W'(exptok_pkg::KW_LEN))
            && (c == KEYWORD[keyword_matched]))
        begin
            keyword_matched = keyword_matched + 1'b1;
        end
        else
        begin
            keyword_possible = 1'b0;
        end
    endtask

    task automatic scan_byte(input logic [exptok_pkg::CHAR_W-1:0] c);
        exptok_pkg::token_t found [2];
        int                 n;
        exptok_pkg::kind_t  k;
        n = 0;
        if (scan_state == exptok_pkg::MODE_IDENT && (char_is_letter(c) || char_is_digit(c)))
        begin
            track_keyword(c);
            position = position + 1'b1;
        end
        else if (scan_state == exptok_pkg::MODE_NUMBER && char_is_digit(c))
        begin
            number_value = exptok_pkg::VALUE_W'(number_value * 10
                         + exptok_pkg::VALUE_W'(c - exptok_pkg::CH_ZERO));
            position = position + 1'b1;
        end
        else
        begin
            if (scan_state == exptok_pkg::MODE_IDENT)
            begin
                if (keyword_possible
                    && keyword_matched == exptok_pkg::KW_W'(exptok_pkg::KW_LEN))
                    found[n] = make_token(exptok_pkg::KIND_RETURN, '0, '0, '0);
                else
                    found[n] = make_token(exptok_pkg::KIND_IDENT, '0,
                                          exptok_pkg::FIELD_W'(word_begin),
                                          exptok_pkg::FIELD_W'(position - word_begin));
                n++;
            end
            else if (scan_state == exptok_pkg::MODE_NUMBER)
            begin
                found[n] = make_token(exptok_pkg::KIND_INT, number_value, '0, '0);
                n++;
                number_value = '0;
            end
            scan_state = exptok_pkg::MODE_IDLE;
            if (c == exptok_pkg::CH_SPACE || c == exptok_pkg::CH_TAB
                || c == exptok_pkg::CH_LF)
            begin
                position = position + 1'b1;
            end
            else if (char_is_letter(c))
            begin
                word_begin = position;
                keyword_matched = '0;
                keyword_possible = 1'b1;
                track_keyword(c);
                scan_state = exptok_pkg::MODE_IDENT;
                position = position + 1'b1;
            end
            else if (char_is_digit(c))
            begin
                number_value = exptok_pkg::VALUE_W'(c - exptok_pkg::CH_ZERO);
                scan_state = exptok_pkg::MODE_NUMBER;
                position = position + 1'b1;
            end
            else
            begin
                k = single_char_kind(c);
                found[n] = make_token(k, '0, '0, '0);
                n++;
                if (k == exptok_pkg::KIND_EOF)
                    restart_scanner();
                else
                    position = position + 1'b1;
            end
        end
        if (n > 0)
            found[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_tokens.push_back(found[i]);
    endtask

    task automatic compare_field(input string name,
                                 input logic [exptok_pkg::VALUE_W-1:0] want,
                                 input logic [exptok_pkg::VALUE_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_scanner();
            expected_tokens.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $error("token of kind %0d arrived with none expected", token_kind);
                    error_count++;
                end
                else
                begin
                    oldest = expected_tokens.pop_front();
                    compare_field("token_kind", exptok_pkg::VALUE_W'(oldest.kind),
                                  exptok_pkg::VALUE_W'(token_kind));
                    compare_field("int_value", oldest.value, int_value);
                    compare_field("ident_start", exptok_pkg::VALUE_W'(oldest.start),
                                  exptok_pkg::VALUE_W'(ident_start));
                    compare_field("ident_length", exptok_pkg::VALUE_W'(oldest.length),
                                  exptok_pkg::VALUE_W'(ident_length));
                    compare_field("last_of_item", exptok_pkg::VALUE_W'(oldest.last),
                                  exptok_pkg::VALUE_W'(last_of_item));
                    checked_count++;
                end
            end
            if (in_valid && !in_stall)
                scan_byte(char_code);
        end
        failures <= error_count;
        outstanding <= expected_tokens.size();
        tokens_checked <= checked_count;
    end

endmodule

// ----- bench/tb_expression_tokenizer.sv -----
`timescale 1ns / 1ps

module tb_expression_tokenizer;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_BYTES = 1870;
    localparam int DRAIN_CYCLES = 20;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [exptok_pkg::CHAR_W-1:0]  char_code;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [3:0]                     token_kind;
    logic [exptok_pkg::VALUE_W-1:0] int_value;
    logic [exptok_pkg::FIELD_W-1:0] ident_start;
    logic [exptok_pkg::FIELD_W-1:0] ident_length;
    logic                           last_of_item;

    int                 failures;
    int                 outstanding;
    int                 tokens_checked;

    int                 cycle_count = 0;
    int                 bytes_sent = 0;
    int                 burst_left = 0;
    int                 stall_style = 0;
    int                 stall_left = 0;
    int                 random_start;

    logic [exptok_pkg::CHAR_W-1:0]  source_text [$];
    string              sample_words [8] = '{"return", "ret", "returns", "Return",
                                             "r", "retur", "returnx", "_9"};

    expression_tokenizer dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .int_value    (int_value),
        .ident_start  (ident_start),
        .ident_length (ident_length),
        .last_of_item (last_of_item)
    );

    expression_tokenizer_checker token_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_code      (char_code),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .token_kind     (token_kind),
        .int_value      (int_value),
        .ident_start    (ident_start),
        .ident_length   (ident_length),
        .last_of_item   (last_of_item),
        .failures       (failures),
        .outstanding    (outstanding),
        .tokens_checked (tokens_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((stall_left % 12) < 7);
        endcase
    end

    function automatic logic [exptok_pkg::CHAR_W-1:0] random_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return exptok_pkg::CHAR_W'(exptok_pkg::CH_LC_A + r);
        else if (r < 52)
            return exptok_pkg::CHAR_W'(exptok_pkg::CH_UC_A + r - 26);
        return exptok_pkg::CH_UNDER;
    endfunction

    function automatic logic [exptok_pkg::CHAR_W-1:0] random_digit();
        return exptok_pkg::CHAR_W'(exptok_pkg::CH_ZERO + $urandom_range(0, 9));
    endfunction

    function automatic logic [exptok_pkg::CHAR_W-1:0] random_word_char();
        if ($urandom_range(0, 4) == 0)
            return random_digit();
        return random_letter();
    endfunction

    function automatic logic [exptok_pkg::CHAR_W-1:0] random_operator();
        case ($urandom_range(0, 3))
            0:       return exptok_pkg::CH_PLUS;
            1:       return exptok_pkg::CH_MINUS;
            2:       return exptok_pkg::CH_STAR;
            default: return exptok_pkg::CH_SLASH;
        endcase
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            source_text.push_back(s[i]);
    endtask

    task automatic push_space();
        repeat ($urandom_range(0, 2))
        begin
            case ($urandom_range(0, 3))
                0:       source_text.push_back(exptok_pkg::CH_TAB);
                1:       source_text.push_back(exptok_pkg::CH_LF);
                default: source_text.push_back(exptok_pkg::CH_SPACE);
            endcase
        end
    endtask

    task automatic push_word();
        if ($urandom_range(0, 2) == 0)
        begin
            push_text(sample_words[$urandom_range(0, 7)]);
        end
        else
        begin
            source_text.push_back(random_letter());
            repeat ($urandom_range(0, 7))
                source_text.push_back(random_word_char());
        end
    endtask

    task automatic push_number();
        int digits;
        digits = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 3);
        repeat (digits)
            source_text.push_back(random_digit());
    endtask

    task automatic push_operand();
        if ($urandom_range(0, 1) == 0)
            push_word();
        else
            push_number();
    endtask

    task automatic push_statement();
        int shape;
        bit grouped;
        shape = $urandom_range(0, 9);
        if (shape <= 6)
        begin
            if (shape == 0)
            begin
                push_text("return");
                source_text.push_back(exptok_pkg::CH_SPACE);
            end
            else
            begin
                push_word();
                push_space();
                source_text.push_back(exptok_pkg::CH_EQ);
            end
            push_space();
            grouped = ($urandom_range(0, 4) == 0);
            if (grouped)
                source_text.push_back(exptok_pkg::CH_LPAREN);
            push_operand();
            repeat ($urandom_range(0, 3))
            begin
                push_space();
                source_text.push_back(random_operator());
                push_space();
                push_operand();
            end
            if (grouped)
                source_text.push_back(exptok_pkg::CH_RPAREN);
            push_space();
            source_text.push_back(exptok_pkg::CH_SEMI);
            push_space();
        end
        else if (shape == 7)
        begin
            repeat ($urandom_range(1, 5))
                source_text.push_back(exptok_pkg::CHAR_W'($urandom_range(1, 255)));
        end
        else if (shape == 8)
        begin
            repeat ($urandom_range(1, 6))
            begin
                case ($urandom_range(0, 5))
                    0:       source_text.push_back(random_letter());
                    1:       source_text.push_back(random_digit());
                    2:       source_text.push_back(random_operator());
                    3:       source_text.push_back(exptok_pkg::CH_EQ);
                    4:       source_text.push_back(($urandom_range(0, 1) == 0)
                                                   ? exptok_pkg::CH_LPAREN
                                                   : exptok_pkg::CH_RPAREN);
                    default: source_text.push_back(exptok_pkg::CH_SEMI);
                endcase
            end
        end
        else
        begin
            source_text.push_back(exptok_pkg::CH_NUL);
            if ($urandom_range(0, 2) == 0)
                source_text.push_back(exptok_pkg::CH_NUL);
        end
    endtask

    task automatic send_byte(input logic [exptok_pkg::CHAR_W-1:0] c);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text();
        while (source_text.size() > 0)
            send_byte(source_text.pop_front());
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        char_code = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        push_text("return;ret(_Za9-42/ \t\n=+");
        source_text.push_back(exptok_pkg::CH_NUL);
        source_text.push_back(exptok_pkg::CH_NUL);
        source_text.push_back(8'hFF);
        source_text.push_back(8'h80);
        source_text.push_back(exptok_pkg::CH_ZERO + 8'd7);
        source_text.push_back(exptok_pkg::CH_NUL);
        send_text();

        random_start = bytes_sent;
        while (bytes_sent < random_start + RANDOM_BYTES)
        begin
            push_statement();
            send_text();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (outstanding != 0)
            $error("%0d expected tokens never arrived", outstanding);

        $display("Fed %0d source bytes in random bursts of statements, stray bytes and ends of text.",
                 bytes_sent);
        $display("Compared %0d tokens while the output stalled in several patterns.",
                 tokens_checked);
        if (failures == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
